/* rtl/hkst_pkg.sv */
// ----------------------------------------------------------------------------
// hkst_pkg
// Shared types and constants of the held key slot tracker.
// ----------------------------------------------------------------------------
package hkst_pkg;

  localparam int unsigned KEY_W          = 25;
  localparam int unsigned TIME_W         = 32;
  localparam int unsigned AMT_W          = 16;
  localparam int unsigned SLOT_COUNT_DEF = 8;

  typedef enum logic [1:0] {
    CMD_PRESS   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_TICK    = 2'd2,
    CMD_QUERY   = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e              command;
    logic [KEY_W-1:0]  key_code;
    logic [AMT_W-1:0]  tick_amount;
  } in_word_t;

  typedef struct packed {
    logic              is_pressed;
    logic [TIME_W-1:0] held_time;
  } out_word_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key_code;
    logic [TIME_W-1:0] held_time;
    logic              is_pressed;
  } slot_t;

  localparam int unsigned SLOT_W = $bits(slot_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } state_e;

  typedef struct packed {
    logic capture;
    logic scan_rd;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic is_query;
    logic out_blocked;
  } dp_sts_t;

endpackage

/* rtl/hkst_ram.sv */
// ----------------------------------------------------------------------------
// hkst_ram
// Generic RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module hkst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/hkst_ctrl.sv */
// ----------------------------------------------------------------------------
// hkst_ctrl
// Controller: accepts a word, sequences the slot scan and the commit step.
// ----------------------------------------------------------------------------
module hkst_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  hkst_pkg::dp_sts_t  sts_i,
  output hkst_pkg::ctl_cmd_t cmd_o
);
  import hkst_pkg::*;

  state_e state_q, state_d;
  logic   commit_ok;

  assign commit_ok = !(sts_i.is_query && sts_i.out_blocked);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (commit_ok) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
      end
      ST_DRAIN: begin
        cmd_o = '0;
      end
      ST_COMMIT: begin
        cmd_o.commit = commit_ok;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

/* rtl/hkst_dp.sv */
// ----------------------------------------------------------------------------
// hkst_dp
// Datapath: slot RAM, scan trackers, tick update and output register.
// ----------------------------------------------------------------------------
module hkst_dp #(
  parameter int unsigned SLOT_COUNT = hkst_pkg::SLOT_COUNT_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hkst_pkg::in_word_t  in_word_i,
  input  hkst_pkg::ctl_cmd_t  cmd_i,
  output hkst_pkg::dp_sts_t   sts_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output hkst_pkg::out_word_t out_word_o
);
  import hkst_pkg::*;

  localparam int unsigned IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  in_word_t          item_q;
  logic [IW-1:0]     addr_q;
  logic              rd_vld_q;
  logic [IW-1:0]     rd_idx_q;
  logic [SLOT_COUNT-1:0] vld_q;

  logic              match_found_q;
  logic [IW-1:0]     match_idx_q;
  logic [TIME_W-1:0] match_time_q;
  logic              match_held_q;
  logic              free_found_q;
  logic [IW-1:0]     free_idx_q;
  logic [TIME_W-1:0] best_time_q;
  logic [IW-1:0]     best_idx_q;

  logic              out_valid_q;
  out_word_t         out_word_q;

  logic [SLOT_W-1:0] ram_rdata;
  slot_t             rd_slot;
  slot_t             wr_slot;
  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  logic [TIME_W:0]   tick_sum;
  logic              tick_we;
  logic              commit_we;
  logic [IW-1:0]     commit_idx;
  slot_t             commit_slot;
  logic              hit;

  hkst_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (SLOT_COUNT),
    .AW    (IW)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wr_slot),
    .re_i    (cmd_i.scan_rd),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  // never-written slots read as zero
  assign rd_slot = vld_q[rd_idx_q] ? slot_t'(ram_rdata) : '0;
  assign hit     = (rd_slot.key_code == item_q.key_code);

  assign tick_sum = {1'b0, rd_slot.held_time} + (TIME_W + 1)'(item_q.tick_amount);
  assign tick_we  = rd_vld_q && (item_q.command == CMD_TICK) && rd_slot.is_pressed;

  always_comb begin
    commit_we   = 1'b0;
    commit_idx  = match_idx_q;
    commit_slot = '0;
    if (cmd_i.commit) begin
      case (item_q.command)
        CMD_PRESS: begin
          commit_we = 1'b1;
          if (match_found_q) begin
            commit_idx = match_idx_q;
          end else if (free_found_q) begin
            commit_idx = free_idx_q;
          end else begin
            commit_idx = best_idx_q;
          end
          commit_slot.key_code   = item_q.key_code;
          commit_slot.held_time  = '0;
          commit_slot.is_pressed = 1'b1;
        end
        CMD_RELEASE: begin
          commit_we              = match_found_q;
          commit_idx             = match_idx_q;
          commit_slot.key_code   = item_q.key_code;
          commit_slot.held_time  = match_time_q;
          commit_slot.is_pressed = 1'b0;
        end
        default: begin
          commit_we = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    ram_we    = tick_we | commit_we;
    ram_waddr = commit_idx;
    wr_slot   = commit_slot;
    if (tick_we) begin
      ram_waddr          = rd_idx_q;
      wr_slot.key_code   = rd_slot.key_code;
      wr_slot.held_time  = tick_sum[TIME_W] ? '1 : tick_sum[TIME_W-1:0];
      wr_slot.is_pressed = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.scan_rd;
      if (ram_we) begin
        vld_q[ram_waddr] <= 1'b1;
      end
      if (cmd_i.commit && (item_q.command == CMD_QUERY)) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= addr_q;
    if (cmd_i.capture) begin
      item_q        <= in_word_i;
      addr_q        <= '0;
      match_found_q <= 1'b0;
      match_idx_q   <= '0;
      match_time_q  <= '0;
      match_held_q  <= 1'b0;
      free_found_q  <= 1'b0;
      free_idx_q    <= '0;
      best_time_q   <= '0;
      best_idx_q    <= '0;
    end else begin
      if (cmd_i.scan_rd) begin
        addr_q <= addr_q + IW'(1);
      end
      if (rd_vld_q) begin
        if (hit && !match_found_q) begin
          match_found_q <= 1'b1;
          match_idx_q   <= rd_idx_q;
          match_time_q  <= rd_slot.held_time;
          match_held_q  <= rd_slot.is_pressed;
        end
        if (!rd_slot.is_pressed && !free_found_q) begin
          free_found_q <= 1'b1;
          free_idx_q   <= rd_idx_q;
        end
        if (rd_slot.held_time > best_time_q) begin
          best_time_q <= rd_slot.held_time;
          best_idx_q  <= rd_idx_q;
        end
      end
    end
    if (cmd_i.commit && (item_q.command == CMD_QUERY)) begin
      out_word_q.is_pressed <= match_held_q;
      out_word_q.held_time  <= match_time_q;
    end
  end

  assign sts_o.scan_last   = (addr_q == IW'(SLOT_COUNT - 1));
  assign sts_o.is_query    = (item_q.command == CMD_QUERY);
  assign sts_o.out_blocked = out_valid_q && out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

/* rtl/held_key_slot_tracker.sv */
// ----------------------------------------------------------------------------
// held_key_slot_tracker
// Key slot table with press, release, tick and query words.
// ----------------------------------------------------------------------------
// Every word passes an accept step, one slot RAM read per slot, a drain step
// and a commit step; a query's commit waits while the output is blocked.
// A query result is registered at commit; new words stall until then.
// Reset clears the control state and a valid flag per slot; unwritten slots
// read as zero, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module held_key_slot_tracker #(
  parameter int unsigned SLOT_COUNT = hkst_pkg::SLOT_COUNT_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  hkst_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output hkst_pkg::out_word_t out_word_o
);
  import hkst_pkg::*;

  ctl_cmd_t ctl_cmd;
  dp_sts_t  dp_sts;

  hkst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (dp_sts),
    .cmd_o      (ctl_cmd)
  );

  hkst_dp #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cmd_i       (ctl_cmd),
    .sts_o       (dp_sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule
